>>> hdl/gspr_pkg.sv
// shared constants, types and the exponential table builder for the gaussian star renderer
// no dependencies; used by every other file of the block
`default_nettype none

package gspr_pkg;

    localparam int MAX_RADIUS       = 7;
    localparam int EXP_TABLE_DEPTH  = 2048;
    localparam int EXP_ADDR_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int SAT_START        = 1386;
    localparam int WHITE_MIN_RADIUS = 5;
    localparam int MAG_BIAS         = 256;
    localparam logic [95:0] ROM_BASE_Q24 = 96'd4280998250;
    localparam logic [95:0] DECAY_Q32    = 96'd4278222805;

    localparam int RADIUS_W = 3;
    localparam int DIM_W    = 11;
    localparam int POS_W    = 12;
    localparam int MAG_W    = 13;
    localparam int OFS_W    = 4;
    localparam int PIX_W    = 24;
    localparam int EXP_W    = 19;

    typedef enum logic [1:0] {
        CFG_ROI_RADIUS   = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_reg_e;

    typedef logic [7:0] exp_rom_t [EXP_TABLE_DEPTH];

    // stage two control and payload
    typedef struct packed {
        logic             draw;
        logic             white;
        logic             remove;
        logic             sat;
        logic             zero;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic [PIX_W-1:0] bg;
    } stage2_t;

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [95:0] acc;
        logic [95:0] r;
        acc = ROM_BASE_Q24;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++)
        begin
            r = (acc + (96'd1 << 23)) >> 24;
            rom[k] = (r > 96'd255) ? 8'd255 : r[7:0];
            acc = (acc * DECAY_Q32 + (96'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

>>> hdl/gspr_stream_if.sv
// valid/ready channel interfaces for star render requests and pixel writes
// depends on gspr_pkg for field widths
`default_nettype none

interface gspr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [gspr_pkg::POS_W-1:0]   star_x;
    logic signed [gspr_pkg::POS_W-1:0]   star_y;
    logic signed [gspr_pkg::MAG_W-1:0]   magnitude_q8;
    logic signed [gspr_pkg::OFS_W-1:0]   col_offset;
    logic signed [gspr_pkg::OFS_W-1:0]   row_offset;
    logic        [gspr_pkg::PIX_W-1:0]   background_pixel;
    logic                                remove_mode;

    modport source (output valid, star_x, star_y, magnitude_q8, col_offset, row_offset,
                    background_pixel, remove_mode, input ready);
    modport sink   (input valid, star_x, star_y, magnitude_q8, col_offset, row_offset,
                    background_pixel, remove_mode, output ready);
endinterface

interface gspr_out_if;
    logic                          valid;
    logic                          ready;
    logic [gspr_pkg::DIM_W-1:0]    pixel_col;
    logic [gspr_pkg::DIM_W-1:0]    pixel_row;
    logic [gspr_pkg::PIX_W-1:0]    pixel_rgb;
    logic                          draw;

    modport source (output valid, pixel_col, pixel_row, pixel_rgb, draw, input ready);
    modport sink   (input valid, pixel_col, pixel_row, pixel_rgb, draw, output ready);
endinterface

`default_nettype wire

>>> hdl/gaussian_star_pixel_render.sv
// top level of the gaussian star pixel renderer: config registers and three-stage pipeline
// depends on gspr_pkg, gspr_stream_if and gspr_exp_rom
//
// usage:
//   pix_in carries one render request per beat: star centre, magnitude, pixel offset,
//   background pixel and mode. pix_out carries one pixel write per request beat, in
//   order; draw low means nothing to write and the other fields are zero.
//   cfg_we/cfg_index/cfg_data write roi_radius, frame_width and frame_height; write
//   only while the pipeline is empty.
//   an accepted request beat passes through the input register, the registered
//   intensity table read and the result register before it becomes its result beat.
//   throughput: one beat per cycle while the receiver keeps pix_out.ready high.
//   each stage advances when the stage after it is empty or moving, so bubbles are
//   squeezed out; when the receiver stalls, the result holds and pix_in.ready drops
//   only once all three stages are full.
//   reset clears all stages and loads roi_radius 5 and a 1400 by 1400 frame.
`default_nettype none

module gaussian_star_pixel_render (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [gspr_pkg::DIM_W-1:0]    cfg_data,
    gspr_in_if.sink                            pix_in,
    gspr_out_if.source                         pix_out
);

    logic [gspr_pkg::RADIUS_W-1:0] roi_radius_reg;
    logic [gspr_pkg::DIM_W-1:0]    frame_width_reg;
    logic [gspr_pkg::DIM_W-1:0]    frame_height_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic signed [gspr_pkg::POS_W-1:0] sx_reg, sy_reg;
    logic signed [gspr_pkg::MAG_W-1:0] mag_reg;
    logic signed [gspr_pkg::OFS_W-1:0] co_reg, ro_reg;
    logic        [gspr_pkg::PIX_W-1:0] bg_reg;
    logic                              remove_reg;

    gspr_pkg::stage2_t s2_next, s2_reg;

    logic signed [gspr_pkg::POS_W:0]   col_s, row_s;
    logic signed [gspr_pkg::OFS_W:0]   co5, ro5;
    logic        [gspr_pkg::OFS_W:0]   aco, aro;
    logic        [gspr_pkg::RADIUS_W-1:0] rad;
    logic        [7:0]                 d2;
    logic signed [gspr_pkg::EXP_W-1:0] t_s, u_s;
    logic                              in_foot, in_frame, white;
    logic        [gspr_pkg::EXP_ADDR_W-1:0] rom_addr;
    logic        [7:0]                 rom_q;

    logic [7:0]                 gray;
    logic [gspr_pkg::PIX_W-1:0] gray_rgb;
    logic [gspr_pkg::PIX_W-1:0] value_next, value_reg;
    logic [gspr_pkg::DIM_W-1:0] col_next, row_next, col_reg, row_reg;
    logic                       draw_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_radius_reg   <= gspr_pkg::RADIUS_W'(5);
            frame_width_reg  <= gspr_pkg::DIM_W'(1400);
            frame_height_reg <= gspr_pkg::DIM_W'(1400);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gspr_pkg::CFG_ROI_RADIUS:   roi_radius_reg   <= cfg_data[gspr_pkg::RADIUS_W-1:0];
                gspr_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                gspr_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables
    assign en3 = !v3_reg || pix_out.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pix_in.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pix_in.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage one: input register
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sx_reg     <= pix_in.star_x;
            sy_reg     <= pix_in.star_y;
            mag_reg    <= pix_in.magnitude_q8;
            co_reg     <= pix_in.col_offset;
            ro_reg     <= pix_in.row_offset;
            bg_reg     <= pix_in.background_pixel;
            remove_reg <= pix_in.remove_mode;
        end
    end

    // footprint, frame test and table address
    always_comb
    begin
        col_s = (gspr_pkg::POS_W+1)'(sx_reg) + (gspr_pkg::POS_W+1)'(co_reg);
        row_s = (gspr_pkg::POS_W+1)'(sy_reg) + (gspr_pkg::POS_W+1)'(ro_reg);
        co5 = (gspr_pkg::OFS_W+1)'(co_reg);
        ro5 = (gspr_pkg::OFS_W+1)'(ro_reg);
        aco = co5[gspr_pkg::OFS_W] ? (gspr_pkg::OFS_W+1)'(-co5) : co5;
        aro = ro5[gspr_pkg::OFS_W] ? (gspr_pkg::OFS_W+1)'(-ro5) : ro5;
        rad = (roi_radius_reg > gspr_pkg::RADIUS_W'(gspr_pkg::MAX_RADIUS))
            ? gspr_pkg::RADIUS_W'(gspr_pkg::MAX_RADIUS) : roi_radius_reg;
        in_foot  = (aco <= (gspr_pkg::OFS_W+1)'(rad)) && (aro <= (gspr_pkg::OFS_W+1)'(rad));
        in_frame = !col_s[gspr_pkg::POS_W]
                && (col_s[gspr_pkg::POS_W-1:0] < gspr_pkg::POS_W'(frame_width_reg))
                && !row_s[gspr_pkg::POS_W]
                && (row_s[gspr_pkg::POS_W-1:0] < gspr_pkg::POS_W'(frame_height_reg));
        white = roi_radius_reg < gspr_pkg::RADIUS_W'(gspr_pkg::WHITE_MIN_RADIUS);
        d2 = (8'(aco) * 8'(aco)) + (8'(aro) * 8'(aro));
        t_s = gspr_pkg::EXP_W'(mag_reg) - gspr_pkg::EXP_W'(gspr_pkg::MAG_BIAS)
            + $signed({2'b00, d2, 9'b0});
        u_s = t_s - gspr_pkg::EXP_W'(gspr_pkg::SAT_START);
        rom_addr = u_s[gspr_pkg::EXP_ADDR_W-1:0];

        s2_next.draw   = in_foot && in_frame && !(white && remove_reg);
        s2_next.white  = white;
        s2_next.remove = remove_reg;
        s2_next.sat    = t_s < $signed(gspr_pkg::EXP_W'(gspr_pkg::SAT_START));
        s2_next.zero   = u_s >= $signed(gspr_pkg::EXP_W'(gspr_pkg::EXP_TABLE_DEPTH));
        s2_next.col    = col_s[gspr_pkg::DIM_W-1:0];
        s2_next.row    = row_s[gspr_pkg::DIM_W-1:0];
        s2_next.bg     = bg_reg;
    end

    gspr_exp_rom u_rom (
        .clk  (clk),
        .en   (en2),
        .addr (rom_addr),
        .data (rom_q)
    );

    // stage two
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_reg <= s2_next;
        end
    end

    always_comb
    begin
        priority if (s2_reg.sat)
            gray = 8'd255;
        else if (s2_reg.zero)
            gray = 8'd0;
        else
            gray = rom_q;
        gray_rgb = {gray, gray, gray};
        priority if (!s2_reg.draw)
            value_next = '0;
        else if (s2_reg.white)
            value_next = {gspr_pkg::PIX_W{1'b1}};
        else if (s2_reg.remove)
            value_next = gray_rgb - s2_reg.bg;
        else
            value_next = gray_rgb + s2_reg.bg;
        col_next = s2_reg.draw ? s2_reg.col : '0;
        row_next = s2_reg.draw ? s2_reg.row : '0;
    end

    // stage three: result register
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            value_reg <= value_next;
            draw_reg  <= s2_reg.draw;
        end
    end

    assign pix_out.valid     = v3_reg;
    assign pix_out.pixel_col = col_reg;
    assign pix_out.pixel_row = row_reg;
    assign pix_out.pixel_rgb = value_reg;
    assign pix_out.draw      = draw_reg;

endmodule

`default_nettype wire

>>> hdl/gspr_exp_rom.sv
// exponential intensity table with registered read port
// depends on gspr_pkg for the table contents and depth
`default_nettype none

module gspr_exp_rom (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [gspr_pkg::EXP_ADDR_W-1:0] addr,
    output logic      [7:0]                      data
);

    localparam gspr_pkg::exp_rom_t ROM = gspr_pkg::build_exp_rom();

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> hdl/gspr_checker.sv
// port-level checks for gaussian_star_pixel_render, attached by bind
// depends on gspr_pkg for field widths
`default_nettype none

module gspr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [gspr_pkg::DIM_W-1:0] pixel_col,
    input wire logic [gspr_pkg::DIM_W-1:0] pixel_row,
    input wire logic [gspr_pkg::PIX_W-1:0] pixel_rgb,
    input wire logic                       draw
);

    // no result beat while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result beat valid during reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_col) && $stable(pixel_row)
            && $stable(pixel_rgb) && $stable(draw))
        else $error("stalled result beat changed");

    // undrawn results carry zeros
    a_undrawn_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !draw |-> pixel_col == '0 && pixel_row == '0 && pixel_rgb == '0)
        else $error("undrawn beat carries nonzero payload");

    // input backpressure only when the receiver stalls a waiting result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // a full pipeline that is drained keeps accepting
    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input not ready while output drains");

endmodule

bind gaussian_star_pixel_render gspr_checker u_gspr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pix_in.ready),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .pixel_col   (pix_out.pixel_col),
    .pixel_row   (pix_out.pixel_row),
    .pixel_rgb   (pix_out.pixel_rgb),
    .draw        (pix_out.draw)
);

`default_nettype wire
